// ----- src/date_advance_days_or_months_defines.svh -----
// ----------------------------------------------------------------------------
// Date advance assertion macros
// Shared property forms for the date advance checker.
// ----------------------------------------------------------------------------
`ifndef DATE_ADVANCE_DAYS_OR_MONTHS_DEFINES_SVH
`define DATE_ADVANCE_DAYS_OR_MONTHS_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DADM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DADM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/dadm_pkg.sv -----
// ----------------------------------------------------------------------------
// Date advance package
// Widths, calendar constants, divider handshake types and month length.
// ----------------------------------------------------------------------------
package dadm_pkg;

	localparam int unsigned MAX_YEAR = 9999;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned TERM_W  = 16;

	// internal year and divider widths
	localparam int unsigned YEAR_IW = 17;
	localparam int unsigned DIV_W   = 17;
	localparam int unsigned REM_W   = 9;
	localparam int unsigned QUO_W   = 14;
	localparam int unsigned MUL_W   = 16;
	localparam int unsigned PROD_W  = 2 * MUL_W;

	// x / 12 as ((x >> 2) * ceil(2^17 / 3)) >> 17
	localparam int unsigned      PRE12_SH    = 2;
	localparam logic [MUL_W-1:0] RECIP12     = 16'hAAAB;
	localparam int unsigned      RECIP12_SH  = 17;
	// x / 400 as ((x >> 4) * ceil(2^15 / 25)) >> 15
	localparam int unsigned      PRE400_SH   = 4;
	localparam logic [MUL_W-1:0] RECIP400    = 16'd1311;
	localparam int unsigned      RECIP400_SH = 15;

	localparam int unsigned MONTHS   = 12;
	localparam int unsigned YEAR_DIV = 400;

	localparam logic MAX_LEAP = ((MAX_YEAR % 400) == 0) ||
		(((MAX_YEAR % 4) == 0) && ((MAX_YEAR % 100) != 0));

	typedef struct packed {
		logic              start;
		logic              div12;
		logic [DIV_W-1:0]  dividend;
	} cdiv_req_t;

	typedef struct packed {
		logic              done;
		logic [QUO_W-1:0]  quot;
		logic [REM_W-1:0]  rem;
	} cdiv_rsp_t;

	function automatic logic leap_of_mod(input logic [REM_W-1:0] r);
		return (r[1:0] == 2'b00) && (r != REM_W'(100)) && (r != REM_W'(200)) &&
			(r != REM_W'(300));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			MONTH_W'(2): len = leap ? DAY_W'(29) : DAY_W'(28);
			MONTH_W'(4), MONTH_W'(6), MONTH_W'(9), MONTH_W'(11): len = DAY_W'(30);
			default: len = DAY_W'(31);
		endcase
		return len;
	endfunction

endpackage

// ----- src/dadm_cdiv.sv -----
// ----------------------------------------------------------------------------
// Date advance constant divider
// Divide by 12 or by 400 through a reciprocal multiply, then a remainder
// from the back-multiplied quotient; start passes quo_go_q, rem_go_q and done_q.
// ----------------------------------------------------------------------------
module dadm_cdiv
	import dadm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cdiv_req_t req,
	output cdiv_rsp_t rsp
);

	logic              sel_q;
	logic              quo_go_q;
	logic              rem_go_q;
	logic              done_q;
	logic [DIV_W-1:0]  arg_q;
	logic [QUO_W-1:0]  quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod;
	logic [QUO_W-1:0]  quo;
	logic [DIV_W-1:0]  back;

	assign mul_a = sel_q ? MUL_W'(arg_q >> PRE12_SH) : MUL_W'(arg_q >> PRE400_SH);
	assign mul_b = sel_q ? RECIP12 : RECIP400;
	assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign quo   = sel_q ? QUO_W'(prod >> RECIP12_SH) : QUO_W'(prod >> RECIP400_SH);
	assign back  = sel_q ? (DIV_W'(quo_q) * DIV_W'(MONTHS)) :
		(DIV_W'(quo_q) * DIV_W'(YEAR_DIV));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q    <= 1'b0;
			quo_go_q <= 1'b0;
			rem_go_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			quo_go_q <= req.start;
			rem_go_q <= quo_go_q;
			done_q   <= rem_go_q;
			if (req.start) begin
				sel_q <= req.div12;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			arg_q <= req.dividend;
		end
		if (quo_go_q) begin
			quo_q <= quo;
		end
		if (rem_go_q) begin
			rem_q <= REM_W'(arg_q - back);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ----- src/date_advance_days_or_months.sv -----
// ----------------------------------------------------------------------------
// Gregorian date advance by days or months
// Input channel in_valid/in_stall carries op, start_year, start_month,
// start_day and term_count; a transaction is taken when in_valid is high
// and in_stall is low. in_stall stays high while one transaction is worked
// on. Output channel out_valid/out_stall returns one result per input
// transaction from an output register; a new input transaction can start
// while the previous result still waits on out_stall.
// Day mode runs a year mod 400 in the reciprocal divider, then a day loop
// that steps one month per cycle through a single subtract-compare.
// Month mode runs a year mod 400, a divide by 12 and a second year mod
// 400 in the shared reciprocal divider; a month-mode result past the last
// year skips the second year mod 400.
// The next transaction is taken the cycle after a result is loaded. While
// out_stall holds a result, a finished transaction waits and in_stall stays
// high.
// Reset clears the sequencer and out_valid; no result is pending after it.
// A result that runs past the last year saturates and sets year_overflow.
// ----------------------------------------------------------------------------
module date_advance_days_or_months
	import dadm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [YEAR_W-1:0]  start_year,
	input  logic [MONTH_W-1:0] start_month,
	input  logic [DAY_W-1:0]   start_day,
	input  logic [TERM_W-1:0]  term_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [YEAR_W-1:0]  end_year,
	output logic [MONTH_W-1:0] end_month,
	output logic [DAY_W-1:0]   end_day,
	output logic               end_is_leap,
	output logic               year_overflow
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SDIV,
		ST_DAY,
		ST_MDIV,
		ST_EDIV,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic                op_q;
	logic                ovf_q;
	logic                out_valid_q;
	logic [YEAR_IW-1:0]  y_q;
	logic [MONTH_W-1:0]  m_q;
	logic [DAY_W-1:0]    d_q;
	logic [REM_W-1:0]    ymod_q;
	logic [TERM_W-1:0]   rem_q;

	cdiv_req_t           dreq;
	cdiv_rsp_t           drsp;

	logic                accept;
	logic                out_load;
	logic [YEAR_IW-1:0]  y_in;
	logic [MONTH_W-1:0]  m_in;
	logic [DAY_W-1:0]    d_in;
	logic [DIV_W-1:0]    total;
	logic [YEAR_IW:0]    y_sum;
	logic [DAY_W-1:0]    len_div;
	logic [DAY_W-1:0]    len_cur;
	logic [DAY_W-1:0]    left;
	logic                cur_leap;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		if (start_year == '0) begin
			y_in = YEAR_IW'(1);
		end else if (YEAR_IW'(start_year) > YEAR_IW'(MAX_YEAR)) begin
			y_in = YEAR_IW'(MAX_YEAR);
		end else begin
			y_in = YEAR_IW'(start_year);
		end
		if (start_month == '0) begin
			m_in = MONTH_W'(1);
		end else if (start_month > MONTH_W'(MONTHS)) begin
			m_in = MONTH_W'(MONTHS);
		end else begin
			m_in = start_month;
		end
		d_in = (start_day == '0) ? DAY_W'(1) : start_day;
	end

	assign total    = DIV_W'(m_q - MONTH_W'(1)) + DIV_W'(rem_q);
	assign y_sum    = (YEAR_IW + 1)'(y_q) + (YEAR_IW + 1)'(drsp.quot);
	assign len_div  = month_len(m_q, leap_of_mod(drsp.rem));
	assign cur_leap = leap_of_mod(ymod_q);
	assign len_cur  = month_len(m_q, cur_leap);
	assign left     = len_cur - d_q;

	always_comb begin
		dreq.start    = 1'b0;
		dreq.div12    = 1'b0;
		dreq.dividend = DIV_W'(y_q);
		case (state_q)
			ST_IDLE: begin
				dreq.start    = accept;
				dreq.dividend = DIV_W'(y_in);
			end
			ST_SDIV: begin
				dreq.start    = drsp.done && op_q;
				dreq.div12    = 1'b1;
				dreq.dividend = total;
			end
			ST_MDIV: begin
				dreq.start    = drsp.done && (y_sum <= (YEAR_IW + 1)'(MAX_YEAR));
				dreq.dividend = DIV_W'(y_sum);
			end
			default: begin
				dreq.start = 1'b0;
			end
		endcase
	end

	dadm_cdiv u_cdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			ovf_q       <= 1'b0;
			op_q        <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= op;
						ovf_q   <= 1'b0;
						state_q <= ST_SDIV;
					end
				end
				ST_SDIV: begin
					if (drsp.done) begin
						state_q <= op_q ? ST_MDIV : ST_DAY;
					end
				end
				ST_DAY: begin
					if (rem_q <= TERM_W'(left)) begin
						state_q <= ST_DONE;
					end else if ((m_q == MONTH_W'(MONTHS)) &&
						(y_q == YEAR_IW'(MAX_YEAR))) begin
						ovf_q   <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_MDIV: begin
					if (drsp.done) begin
						if (y_sum > (YEAR_IW + 1)'(MAX_YEAR)) begin
							ovf_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_EDIV;
						end
					end
				end
				ST_EDIV: begin
					if (drsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					y_q   <= y_in;
					m_q   <= m_in;
					d_q   <= d_in;
					rem_q <= term_count;
				end
			end
			ST_SDIV, ST_EDIV: begin
				if (drsp.done) begin
					ymod_q <= drsp.rem;
					if (d_q > len_div) begin
						d_q <= len_div;
					end
				end
			end
			ST_DAY: begin
				if (rem_q <= TERM_W'(left)) begin
					d_q   <= d_q + rem_q[DAY_W-1:0];
					rem_q <= '0;
				end else begin
					rem_q <= rem_q - TERM_W'(left) - TERM_W'(1);
					d_q   <= DAY_W'(1);
					if (m_q == MONTH_W'(MONTHS)) begin
						m_q    <= MONTH_W'(1);
						y_q    <= y_q + YEAR_IW'(1);
						ymod_q <= (ymod_q == REM_W'(YEAR_DIV - 1)) ? '0 :
							ymod_q + REM_W'(1);
					end else begin
						m_q <= m_q + MONTH_W'(1);
					end
				end
			end
			ST_MDIV: begin
				if (drsp.done) begin
					m_q <= MONTH_W'(drsp.rem) + MONTH_W'(1);
					y_q <= y_sum[YEAR_IW-1:0];
				end
			end
			default: begin
				y_q <= y_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (ovf_q) begin
				end_year      <= YEAR_W'(MAX_YEAR);
				end_month     <= MONTH_W'(MONTHS);
				end_day       <= DAY_W'(31);
				end_is_leap   <= MAX_LEAP;
				year_overflow <= 1'b1;
			end else begin
				end_year      <= y_q[YEAR_W-1:0];
				end_month     <= m_q;
				end_day       <= d_q;
				end_is_leap   <= cur_leap;
				year_overflow <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/dadm_checker.sv -----
// ----------------------------------------------------------------------------
// Date advance port checker
// Port-level properties of the date advance block, bound to the top level.
// ----------------------------------------------------------------------------
`include "date_advance_days_or_months_defines.svh"

module dadm_checker
	import dadm_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               op,
	input logic [YEAR_W-1:0]  start_year,
	input logic [MONTH_W-1:0] start_month,
	input logic [DAY_W-1:0]   start_day,
	input logic [TERM_W-1:0]  term_count,
	input logic               out_valid,
	input logic               out_stall,
	input logic [YEAR_W-1:0]  end_year,
	input logic [MONTH_W-1:0] end_month,
	input logic [DAY_W-1:0]   end_day,
	input logic               end_is_leap,
	input logic               year_overflow
);

	`DADM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not held off after transaction")

	`DADM_ASSERT_SAME(a_ovf_saturate, out_valid && year_overflow, (end_year == YEAR_W'(MAX_YEAR)) && (end_month == MONTH_W'(MONTHS)) && (end_day == DAY_W'(31)), "overflow result not saturated")

	`DADM_ASSERT_SAME(a_feb_len, out_valid && (end_month == MONTH_W'(2)), (end_day <= DAY_W'(28)) || (end_is_leap && (end_day == DAY_W'(29))), "February day beyond month length")

	`DADM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(end_year) && $stable(end_month) && $stable(end_day), "stalled result changed")

endmodule

bind date_advance_days_or_months dadm_checker u_dadm_checker (.*);
